// File: sv/dwc_pkg.sv
// ----------------------------------------------------------------------------
// dwc_pkg
// types and constants for the depthwise 3x3 requant core
// ----------------------------------------------------------------------------
package dwc_pkg;

  localparam int DEF_MAX_SIDE = 256;
  localparam int KSIDE        = 3;
  localparam int PIX_W        = 8;
  localparam int TAG_W        = 8;
  localparam int CFG_W        = 32;
  localparam int CFG_IDX_W    = 3;
  localparam int SUM_W        = 19;
  localparam int QFRAC        = 24;

  localparam logic [CFG_IDX_W-1:0] REG_SIDE  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_KTOP  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_KMID  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_KBOT  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_SCALE = 3'd4;

  localparam logic signed [PIX_W-1:0] SAT_MIN = -8'sd128;
  localparam logic signed [PIX_W-1:0] SAT_MAX = 8'sd127;

  // one classified job: window snapshot plus up to four result requests
  typedef struct packed {
    logic [8:0][PIX_W-1:0] win;
    logic [TAG_W-1:0]      row;
    logic [TAG_W-1:0]      col;
    logic                  two_rows;
    logic                  two_cols;
    logic                  top_edge;
    logic                  left_edge;
    logic                  bot_in;
    logic                  right_in;
  } job_t;

endpackage

// File: sv/int8_depthwise_conv3x3_requant_core.sv
// ----------------------------------------------------------------------------
// int8_depthwise_conv3x3_requant_core
// 3x3 depthwise int8 convolution, zero padding, Q8.24 requantization
// ----------------------------------------------------------------------------
// channel  dir  handshake            payload
// in       in   in_valid/in_ready    in_pixel_value
// out      out  out_valid/out_ready  out_value, out_row, out_col, out_run_last
// cfg      in   cfg_we               cfg_index, cfg_data
//
// front reads the line stores as it takes a pixel, then writes and shifts before the next
// back runs each result through mac, scale and output states, idling after each job,
// with up to 4 results per pixel at the far edges
// synchronous active-low reset clears counters, window and queue
// a full job queue stalls the front; out_ready low stalls the back
module int8_depthwise_conv3x3_requant_core #(
  parameter int MAX_SIDE = dwc_pkg::DEF_MAX_SIDE
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_we,
  input  logic [dwc_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [dwc_pkg::CFG_W-1:0]         cfg_data,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic signed [dwc_pkg::PIX_W-1:0]  in_pixel_value,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic signed [dwc_pkg::PIX_W-1:0]  out_value,
  output logic [dwc_pkg::TAG_W-1:0]         out_row,
  output logic [dwc_pkg::TAG_W-1:0]         out_col,
  output logic                              out_run_last
);
  import dwc_pkg::*;

  localparam int CW = $clog2(MAX_SIDE + 1);

  logic [8:0]  side_r;
  logic [23:0] ktop_r, kmid_r, kbot_r;
  logic [31:0] scale_r;
  logic [CW-1:0] side_eff;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      side_r  <= 9'd96;
      ktop_r  <= '0;
      kmid_r  <= 24'd256;
      kbot_r  <= '0;
      scale_r <= 32'h0100_0000;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_SIDE:  side_r  <= cfg_data[8:0];
        REG_KTOP:  ktop_r  <= cfg_data[23:0];
        REG_KMID:  kmid_r  <= cfg_data[23:0];
        REG_KBOT:  kbot_r  <= cfg_data[23:0];
        REG_SCALE: scale_r <= cfg_data;
        default: ;
      endcase
    end
  end

  always_comb begin
    if (side_r == '0)                    side_eff = CW'(1);
    else if (32'(side_r) > MAX_SIDE)     side_eff = CW'(MAX_SIDE);
    else                                 side_eff = CW'(side_r);
  end

  logic fj_valid, fj_ready, bj_valid, bj_ready;
  job_t fj, bj;

  dwc_front #(.MAX_SIDE(MAX_SIDE), .CW(CW)) u_front (
    .clk, .rst_n, .side(side_eff), .in_valid, .in_ready, .pix(in_pixel_value),
    .job_valid(fj_valid), .job_ready(fj_ready), .job(fj)
  );

  dwc_fifo u_fifo (
    .clk, .rst_n, .wr_valid(fj_valid), .wr_ready(fj_ready), .wr_data(fj),
    .rd_valid(bj_valid), .rd_ready(bj_ready), .rd_data(bj)
  );

  logic [PIX_W-1:0] val_u;

  dwc_back u_back (
    .clk, .rst_n, .k_top(ktop_r), .k_mid(kmid_r), .k_bot(kbot_r), .scale(scale_r),
    .job_valid(bj_valid), .job_ready(bj_ready), .job(bj),
    .out_valid, .out_ready, .out_value(val_u), .out_row, .out_col,
    .run_last(out_run_last)
  );

  assign out_value = $signed(val_u);

  a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready) else $error("front took two pixels back to back");
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid) else $error("result dropped while stalled");
  a_queue: assert property (@(posedge clk) disable iff (!rst_n)
    bj_ready |-> bj_valid) else $error("back popped an empty queue");

endmodule

// File: sv/dwc_front.sv
// ----------------------------------------------------------------------------
// dwc_front
// accepts pixels, runs line stores and window, classifies result requests
// ----------------------------------------------------------------------------
module dwc_front #(
  parameter int MAX_SIDE = dwc_pkg::DEF_MAX_SIDE,
  parameter int CW       = $clog2(MAX_SIDE + 1)
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic [CW-1:0]             side,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic [dwc_pkg::PIX_W-1:0] pix,
  output logic                      job_valid,
  input  logic                      job_ready,
  output dwc_pkg::job_t             job
);
  import dwc_pkg::*;

  localparam int AW = $clog2(MAX_SIDE);

  logic [PIX_W-1:0] up_mem [MAX_SIDE];
  logic [PIX_W-1:0] lo_mem [MAX_SIDE];
  logic [8:0][PIX_W-1:0] win_r, win_nxt;
  logic [CW-1:0] row_r, row_nxt, col_r, col_nxt;
  logic [CW-1:0] r, c;
  logic          st_r, st_nxt;
  logic [PIX_W-1:0] pix_r, top_rd_r, mid_rd_r;
  logic [CW-1:0] pr_r, pc_r;
  logic          jv_r, jv_nxt;
  job_t          job_r, job_nxt;
  logic          acc, rd_phase;

  // two steps per pixel: read stores, then shift window and emit job
  assign in_ready = !st_r && (!jv_r || job_ready);
  assign acc      = in_valid && in_ready;
  assign rd_phase = st_r;

  always_comb begin
    r = row_r;
    c = col_r;
    if (row_r >= side || col_r >= side) begin
      r = '0;
      c = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      top_rd_r <= up_mem[c[AW-1:0]];
      mid_rd_r <= lo_mem[c[AW-1:0]];
      pix_r    <= pix;
      pr_r     <= r;
      pc_r     <= c;
    end
    if (rd_phase) begin
      up_mem[pc_r[AW-1:0]] <= mid_rd_r;
      lo_mem[pc_r[AW-1:0]] <= pix_r;
    end
  end

  always_comb begin
    row_nxt = row_r;
    col_nxt = col_r;
    st_nxt  = st_r;
    win_nxt = win_r;
    jv_nxt  = jv_r;
    job_nxt = job_r;
    if (job_valid && job_ready) jv_nxt = 1'b0;
    if (acc) begin
      st_nxt = 1'b1;
      if (c + CW'(1) >= side) begin
        col_nxt = '0;
        row_nxt = (r + CW'(1) >= side) ? '0 : r + CW'(1);
      end else begin
        col_nxt = c + CW'(1);
      end
    end
    if (rd_phase) begin
      st_nxt = 1'b0;
      win_nxt[0] = win_r[1]; win_nxt[1] = win_r[2]; win_nxt[2] = top_rd_r;
      win_nxt[3] = win_r[4]; win_nxt[4] = win_r[5]; win_nxt[5] = mid_rd_r;
      win_nxt[6] = win_r[7]; win_nxt[7] = win_r[8]; win_nxt[8] = pix_r;
      job_nxt.win       = win_nxt;
      job_nxt.two_rows  = (pr_r == side - CW'(1)) && (pr_r != '0);
      job_nxt.two_cols  = (pc_r == side - CW'(1)) && (pc_r != '0);
      job_nxt.row       = TAG_W'((pr_r == '0) ? pr_r : pr_r - CW'(1));
      job_nxt.col       = TAG_W'((pc_r == '0) ? pc_r : pc_r - CW'(1));
      job_nxt.top_edge  = (pr_r <= CW'(1));
      job_nxt.left_edge = (pc_r <= CW'(1));
      job_nxt.bot_in    = (pr_r != '0);
      job_nxt.right_in  = (pc_r != '0);
      // window anchored with center at (r-1,c-1); for r==0 or c==0 alone no result
      jv_nxt = (pr_r == side - CW'(1) || pr_r != '0) &&
               (pc_r == side - CW'(1) || pc_r != '0);
      if (pr_r == '0) job_nxt.row = '0;
      if (pc_r == '0) job_nxt.col = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_r <= '0;
      col_r <= '0;
      st_r  <= 1'b0;
      jv_r  <= 1'b0;
      win_r <= '0;
    end else begin
      row_r <= row_nxt;
      col_r <= col_nxt;
      st_r  <= st_nxt;
      jv_r  <= jv_nxt;
      win_r <= win_nxt;
    end
    job_r <= job_nxt;
  end

  assign job_valid = jv_r;
  assign job       = job_r;

endmodule

// File: sv/dwc_fifo.sv
// ----------------------------------------------------------------------------
// dwc_fifo
// two-entry queue of jobs between front and back
// ----------------------------------------------------------------------------
module dwc_fifo (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          wr_valid,
  output logic          wr_ready,
  input  dwc_pkg::job_t wr_data,
  output logic          rd_valid,
  input  logic          rd_ready,
  output dwc_pkg::job_t rd_data
);
  import dwc_pkg::*;

  job_t       mem_r [2];
  logic       wp_r, rp_r;
  logic [1:0] cnt_r;
  logic       wr, rd;

  assign wr_ready = cnt_r != 2'd2;
  assign rd_valid = cnt_r != 2'd0;
  assign rd_data  = mem_r[rp_r];
  assign wr = wr_valid && wr_ready;
  assign rd = rd_valid && rd_ready;

  always_ff @(posedge clk) begin
    if (wr) mem_r[wp_r] <= wr_data;
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= '0;
    end else begin
      if (wr) wp_r <= !wp_r;
      if (rd) rp_r <= !rp_r;
      cnt_r <= cnt_r + 2'(wr) - 2'(rd);
    end
  end

endmodule

// File: sv/dwc_back.sv
// ----------------------------------------------------------------------------
// dwc_back
// walks the results of one job: mac, scale, round, saturate
// ----------------------------------------------------------------------------
module dwc_back (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic [23:0]               k_top,
  input  logic [23:0]               k_mid,
  input  logic [23:0]               k_bot,
  input  logic [31:0]               scale,
  input  logic                      job_valid,
  output logic                      job_ready,
  input  dwc_pkg::job_t             job,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic [dwc_pkg::PIX_W-1:0] out_value,
  output logic [dwc_pkg::TAG_W-1:0] out_row,
  output logic [dwc_pkg::TAG_W-1:0] out_col,
  output logic                      run_last
);
  import dwc_pkg::*;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_MAC  = 2'd1;
  localparam logic [1:0] S_MUL  = 2'd2;
  localparam logic [1:0] S_OUT  = 2'd3;

  logic [1:0] st_r, st_nxt;
  logic [1:0] sub_r, sub_nxt;
  logic [1:0] n_r, n_nxt;
  logic       last_r, last_nxt;
  logic signed [SUM_W-1:0] sum_r, sum_nxt;
  logic [50:0] prod_r;
  logic        neg_r;
  logic [PIX_W-1:0] val_r, val_nxt;
  logic [TAG_W-1:0] orow_r, ocol_r, orow_nxt, ocol_nxt;
  logic [8:0][7:0] kw;
  logic [8:0] vis;
  logic       dy, dx, top_pad, left_pad, bot_pad, right_pad;
  logic       oy, ox;
  logic signed [SUM_W-1:0] mac;
  logic [SUM_W-1:0] mag;
  logic [26:0] q;

  assign kw = {k_bot, k_mid, k_top};
  assign dy = sub_r[1];
  assign dx = sub_r[0];
  // a one-pixel image has its only pixel in the newest window row and column
  assign oy = dy || !job.bot_in;
  assign ox = dx || !job.right_in;

  // visible taps of the 3x3 window for the chosen sub-result
  always_comb begin
    top_pad   = dy ? 1'b0 : job.top_edge;
    left_pad  = dx ? 1'b0 : job.left_edge;
    bot_pad   = dy || !job.bot_in;
    right_pad = dx || !job.right_in;
    for (int ky = 0; ky < KSIDE; ky++) begin
      for (int kx = 0; kx < KSIDE; kx++) begin
        vis[ky*3+kx] = !((ky == 0 && top_pad) || (ky == 2 && bot_pad) ||
                         (kx == 0 && left_pad) || (kx == 2 && right_pad));
      end
    end
    mac = '0;
    for (int i = 0; i < 9; i++) begin
      logic [3:0] wy, wx;
      wy = 4'(i / 3) + 4'(oy);
      wx = 4'(i % 3) + 4'(ox);
      if (vis[i] && wy < 4'd3 && wx < 4'd3) begin
        mac = mac + SUM_W'($signed(job.win[wy*3+wx]) * $signed(kw[i]));
      end
    end
  end

  // last result of job: the largest sub-index in use
  always_comb begin
    st_nxt   = st_r;
    sub_nxt  = sub_r;
    n_nxt    = n_r;
    last_nxt = last_r;
    sum_nxt  = sum_r;
    val_nxt  = val_r;
    orow_nxt = orow_r;
    ocol_nxt = ocol_r;
    job_ready = 1'b0;
    mag = sum_r[SUM_W-1] ? SUM_W'(-sum_r) : SUM_W'(sum_r);
    q   = 27'(({prod_r} + 51'(1 << (QFRAC - 1))) >> QFRAC);
    case (st_r)
      S_IDLE: begin
        if (job_valid) begin
          sub_nxt = 2'd0;
          st_nxt  = S_MAC;
        end
      end
      S_MAC: begin
        sum_nxt  = mac;
        orow_nxt = job.row + TAG_W'(dy);
        ocol_nxt = job.col + TAG_W'(dx);
        last_nxt = (dy == job.two_rows) && (dx == job.two_cols);
        st_nxt   = S_MUL;
      end
      S_MUL: begin
        st_nxt = S_OUT;
      end
      S_OUT: begin
        if (neg_r) val_nxt = (q > 27'd128) ? SAT_MIN : PIX_W'(-q);
        else       val_nxt = (q > 27'd127) ? SAT_MAX : PIX_W'(q);
        if (!out_valid || out_ready) begin
          if (last_r) begin
            job_ready = 1'b1;
            st_nxt    = S_IDLE;
          end else begin
            if (dx == 1'b0 && job.two_cols) sub_nxt = {dy, 1'b1};
            else                            sub_nxt = {1'b1, 1'b0};
            st_nxt = S_MAC;
          end
        end
      end
      default: st_nxt = S_IDLE;
    endcase
    n_nxt = n_r;
  end

  logic ov_r;
  logic load_out;
  assign load_out = (st_r == S_OUT) && (!ov_r || out_ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r  <= S_IDLE;
      ov_r  <= 1'b0;
      sub_r <= '0;
      n_r   <= '0;
    end else begin
      st_r  <= st_nxt;
      sub_r <= sub_nxt;
      n_r   <= n_nxt;
      if (load_out) ov_r <= 1'b1;
      else if (out_ready) ov_r <= 1'b0;
    end
    sum_r  <= sum_nxt;
    last_r <= last_nxt;
    orow_r <= orow_nxt;
    ocol_r <= ocol_nxt;
    if (st_r == S_MAC) begin
      prod_r <= '0;
    end
    if (st_r == S_MUL) begin
      prod_r <= 51'(mag) * 51'(scale);
      neg_r  <= sum_r[SUM_W-1];
    end
    if (load_out) begin
      val_r    <= val_nxt;
      out_row  <= orow_r;
      out_col  <= ocol_r;
      run_last <= last_r;
    end
  end

  assign out_valid = ov_r;
  assign out_value = val_r;

endmodule

// File: verif/tb_int8_depthwise_conv3x3_requant_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_int8_depthwise_conv3x3_requant_core
// self-checking bench for the depthwise 3x3 int8 requant core: a directed
// table of config writes and pixels, a partial frame at the largest side,
// then random frames with random kernels and scales. a line-store and window
// predictor builds the expected results, checked field by field in order.
// ----------------------------------------------------------------------------
module tb_int8_depthwise_conv3x3_requant_core;
  import dwc_pkg::*;

  typedef enum logic {ROW_CFG, ROW_PIX} row_kind_t;

  typedef struct {
    row_kind_t            kind;
    logic [CFG_IDX_W-1:0] idx;
    logic [CFG_W-1:0]     data;
    logic signed [7:0]    pix;
    bit                   has_exp;
    logic signed [7:0]    exp_value;
  } stim_row_t;

  typedef struct {
    logic signed [7:0] value;
    logic [7:0]        row;
    logic [7:0]        col;
    logic              last;
  } conv_result_t;

  localparam logic [CFG_IDX_W-1:0] REG_UNUSED_LO = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED_HI = 3'd7;
  localparam int SETTLE_CYCLES = 40;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_W-1:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic signed [7:0] in_pixel_value = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic signed [7:0] out_value;
  logic [7:0] out_row;
  logic [7:0] out_col;
  logic out_run_last;

  int8_depthwise_conv3x3_requant_core dut (
    .clk(clk), .rst_n(rst_n),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_ready(in_ready), .in_pixel_value(in_pixel_value),
    .out_valid(out_valid), .out_ready(out_ready), .out_value(out_value),
    .out_row(out_row), .out_col(out_col), .out_run_last(out_run_last)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // predictor state
  logic [8:0]  side_reg;
  logic [23:0] krow [3];
  logic [31:0] scale_reg;
  logic [7:0]  upper_line [256];
  logic [7:0]  lower_line [256];
  logic [7:0]  win [9];
  int unsigned row_cnt, col_cnt;

  conv_result_t pending_results[$];
  conv_result_t step_results[$];
  int n_err = 0;

  function automatic int eff_side();
    if (side_reg == 0) return 1;
    if (side_reg > 256) return 256;
    return side_reg;
  endfunction

  function automatic int win_pixel(int py, int px, int r, int c, int s);
    int wr, wc;
    if (py < 0 || px < 0 || py >= s || px >= s) return 0;
    wr = py - (r - 2);
    wc = px - (c - 2);
    if (wr < 0 || wc < 0 || wr > 2 || wc > 2) return 0;
    return $signed(win[wr * 3 + wc]);
  endfunction

  function automatic logic signed [7:0] requantize(int acc);
    longint unsigned mag, q;
    mag = (acc < 0) ? -acc : acc;
    q = (mag * scale_reg + (64'd1 << (QFRAC - 1))) >> QFRAC;
    if (acc < 0) return (q > 128) ? SAT_MIN : -$signed(q[7:0]);
    return (q > 127) ? SAT_MAX : q[7:0];
  endfunction

  function automatic logic signed [7:0] conv_pixel(int y, int x, int r, int c, int s);
    int acc;
    logic signed [7:0] w;
    acc = 0;
    for (int ky = 0; ky < 3; ky++)
      for (int kx = 0; kx < 3; kx++) begin
        w = krow[ky][8*kx +: 8];
        acc += win_pixel(y + ky - 1, x + kx - 1, r, c, s) * int'(w);
      end
    return requantize(acc);
  endfunction

  function automatic void reset_model();
    side_reg = 9'd96;
    krow[0] = 24'h0; krow[1] = 24'h000100; krow[2] = 24'h0;
    scale_reg = 32'h0100_0000;
    foreach (win[i]) win[i] = '0;
    foreach (upper_line[i]) begin
      upper_line[i] = '0;
      lower_line[i] = '0;
    end
    row_cnt = 0;
    col_cnt = 0;
  endfunction

  function automatic void model_cfg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] d);
    case (idx)
      REG_SIDE:  side_reg = d[8:0];
      REG_KTOP:  krow[0] = d[23:0];
      REG_KMID:  krow[1] = d[23:0];
      REG_KBOT:  krow[2] = d[23:0];
      REG_SCALE: scale_reg = d;
      default: ;
    endcase
  endfunction

  // fills step_results with the results one pixel causes
  function automatic void predict_pixel(logic signed [7:0] p);
    int s, r, c, ny, nx;
    int ys[2], xs[2];
    logic [7:0] top, mid;
    conv_result_t res;
    s = eff_side();
    step_results.delete();
    if (row_cnt >= s || col_cnt >= s) begin
      row_cnt = 0;
      col_cnt = 0;
    end
    r = row_cnt;
    c = col_cnt;
    top = upper_line[c];
    mid = lower_line[c];
    upper_line[c] = mid;
    lower_line[c] = p;
    for (int k = 0; k < 3; k++) begin
      win[k*3] = win[k*3+1];
      win[k*3+1] = win[k*3+2];
    end
    win[2] = top; win[5] = mid; win[8] = p;
    ny = 0; nx = 0;
    if (r >= 1) begin
      ys[ny] = r - 1;
      ny = ny + 1;
    end
    if (r == s - 1) begin
      ys[ny] = r;
      ny = ny + 1;
    end
    if (c >= 1) begin
      xs[nx] = c - 1;
      nx = nx + 1;
    end
    if (c == s - 1) begin
      xs[nx] = c;
      nx = nx + 1;
    end
    for (int i = 0; i < ny; i++)
      for (int j = 0; j < nx; j++) begin
        res.value = conv_pixel(ys[i], xs[j], r, c, s);
        res.row = ys[i][7:0];
        res.col = xs[j][7:0];
        res.last = (i == ny - 1) && (j == nx - 1);
        step_results.push_back(res);
      end
    if (c + 1 >= s) begin
      col_cnt = 0;
      row_cnt = (r + 1 >= s) ? 0 : r + 1;
    end else begin
      col_cnt = c + 1;
    end
  endfunction

  // receiver stall pattern
  int stall_mode = 0;
  int stall_left = 0;
  always @(posedge clk) begin
    if (stall_left == 0) begin
      stall_mode <= $urandom_range(0, 3);
      stall_left <= $urandom_range(10, 80);
    end else begin
      stall_left <= stall_left - 1;
    end
    case (stall_mode)
      0: out_ready <= 1'b1;
      1: out_ready <= $urandom_range(0, 1);
      2: out_ready <= ($urandom_range(0, 7) == 0);
      default: out_ready <= ($urandom_range(0, 3) != 0);
    endcase
  end

  always @(posedge clk) begin
    conv_result_t e;
    if (rst_n && out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        $error("unexpected result value=%0d row=%0d col=%0d", out_value, out_row, out_col);
        n_err++;
      end else begin
        e = pending_results.pop_front();
        if (out_value !== e.value) begin
          $error("out_value expected %0d actual %0d", e.value, out_value);
          n_err++;
        end
        if (out_row !== e.row) begin
          $error("out_row expected %0d actual %0d", e.row, out_row);
          n_err++;
        end
        if (out_col !== e.col) begin
          $error("out_col expected %0d actual %0d", e.col, out_col);
          n_err++;
        end
        if (out_run_last !== e.last) begin
          $error("out_run_last expected %0d actual %0d", e.last, out_run_last);
          n_err++;
        end
      end
    end
  end

  int burst_left = 0;

  task automatic send_pixel(logic signed [7:0] p, bit has_exp, logic signed [7:0] exp_v);
    conv_result_t res;
    in_valid <= 1'b1;
    in_pixel_value <= p;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    predict_pixel(p);
    if (has_exp) begin
      res.value = exp_v; res.row = 8'd0; res.col = 8'd0; res.last = 1'b1;
      pending_results.push_back(res);
    end else begin
      foreach (step_results[i]) pending_results.push_back(step_results[i]);
    end
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      burst_left = $urandom_range(1, 24);
      if ($urandom_range(0, 2) != 0) begin
        in_valid <= 1'b0;
        repeat ($urandom_range(1, 9)) @(posedge clk);
      end
    end
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] d);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= d;
    model_cfg(idx, d);
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  function automatic logic signed [7:0] rand_pixel();
    case ($urandom_range(0, 9))
      0: return SAT_MIN;
      1: return SAT_MAX;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  stim_row_t directed[$] = '{
    '{ROW_CFG, REG_SIDE,      32'd1,         8'sd0,    1'b0, 8'sd0},
    '{ROW_PIX, REG_SIDE,      32'd0,         -8'sd128, 1'b1, -8'sd128},
    '{ROW_PIX, REG_SIDE,      32'd0,         8'sd127,  1'b1, 8'sd127},
    '{ROW_PIX, REG_SIDE,      32'd0,         8'sd0,    1'b1, 8'sd0},
    '{ROW_CFG, REG_SCALE,     32'hFFFF_FFFF, 8'sd0,    1'b0, 8'sd0},
    '{ROW_PIX, REG_SIDE,      32'd0,         8'sd1,    1'b1, 8'sd127},
    '{ROW_PIX, REG_SIDE,      32'd0,         -8'sd1,   1'b1, -8'sd128},
    '{ROW_CFG, REG_SCALE,     32'd0,         8'sd0,    1'b0, 8'sd0},
    '{ROW_PIX, REG_SIDE,      32'd0,         8'sd127,  1'b1, 8'sd0},
    '{ROW_CFG, REG_UNUSED_LO, 32'd123,       8'sd0,    1'b0, 8'sd0},
    '{ROW_CFG, REG_UNUSED_HI, 32'hFFFF_FFFF, 8'sd0,    1'b0, 8'sd0},
    '{ROW_CFG, REG_SCALE,     32'h0100_0000, 8'sd0,    1'b0, 8'sd0},
    '{ROW_PIX, REG_SIDE,      32'd0,         8'sd55,   1'b1, 8'sd55},
    '{ROW_CFG, REG_KTOP,      32'h0080_8080, 8'sd0,    1'b0, 8'sd0},
    '{ROW_CFG, REG_KMID,      32'h0080_8080, 8'sd0,    1'b0, 8'sd0},
    '{ROW_CFG, REG_KBOT,      32'h0080_8080, 8'sd0,    1'b0, 8'sd0},
    '{ROW_CFG, REG_SIDE,      32'd2,         8'sd0,    1'b0, 8'sd0},
    '{ROW_PIX, REG_SIDE,      32'd0,         -8'sd128, 1'b0, 8'sd0},
    '{ROW_PIX, REG_SIDE,      32'd0,         -8'sd128, 1'b0, 8'sd0},
    '{ROW_PIX, REG_SIDE,      32'd0,         -8'sd128, 1'b0, 8'sd0},
    '{ROW_PIX, REG_SIDE,      32'd0,         -8'sd128, 1'b0, 8'sd0},
    '{ROW_CFG, REG_KTOP,      32'h007F_7F7F, 8'sd0,    1'b0, 8'sd0},
    '{ROW_CFG, REG_KMID,      32'h007F_7F7F, 8'sd0,    1'b0, 8'sd0},
    '{ROW_CFG, REG_KBOT,      32'h007F_7F7F, 8'sd0,    1'b0, 8'sd0},
    '{ROW_CFG, REG_SIDE,      32'd0,         8'sd0,    1'b0, 8'sd0},
    '{ROW_PIX, REG_SIDE,      32'd0,         8'sd127,  1'b0, 8'sd0},
    '{ROW_PIX, REG_SIDE,      32'd0,         -8'sd128, 1'b0, 8'sd0},
    '{ROW_CFG, REG_SIDE,      32'd511,       8'sd0,    1'b0, 8'sd0}
  };

  initial begin
    int rand_items, s, frames;
    reset_model();
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (directed[i]) begin
      if (directed[i].kind == ROW_CFG) begin
        drain();
        write_reg(directed[i].idx, directed[i].data);
      end else begin
        send_pixel(directed[i].pix, directed[i].has_exp, directed[i].exp_value);
      end
    end

    // partial frame at the largest side, then restart from a fresh frame
    write_reg(REG_KMID, $urandom_range(0, 24'hFFFFFF));
    write_reg(REG_SCALE, 32'h0040_0000);
    for (int i = 0; i < 40; i++) send_pixel(rand_pixel(), 1'b0, 8'sd0);
    drain();
    write_reg(REG_SIDE, 32'd1);
    send_pixel(rand_pixel(), 1'b0, 8'sd0);

    rand_items = 0;
    while (rand_items < 150) begin
      drain();
      s = ($urandom_range(0, 9) < 7) ? $urandom_range(1, 6) : $urandom_range(7, 12);
      frames = $urandom_range(1, 2);
      if (rand_items + frames * s * s > 160) frames = 1;
      while (s > 1 && rand_items + s * s > 160) s--;
      write_reg(REG_SIDE, s);
      write_reg(REG_KTOP, $urandom_range(0, 24'hFFFFFF));
      write_reg(REG_KMID, $urandom_range(0, 24'hFFFFFF));
      write_reg(REG_KBOT, $urandom_range(0, 24'hFFFFFF));
      case ($urandom_range(0, 3))
        0: write_reg(REG_SCALE, $urandom());
        1: write_reg(REG_SCALE, 32'd1 << $urandom_range(12, 24));
        2: write_reg(REG_SCALE, $urandom_range(0, 32'h00FF_FFFF) >> $urandom_range(0, 8));
        default: write_reg(REG_SCALE, $urandom_range(32'h0000_4000, 32'h0002_0000));
      endcase
      for (int f = 0; f < frames * s * s; f++) begin
        send_pixel(rand_pixel(), 1'b0, 8'sd0);
        rand_items++;
      end
    end

    drain();
    if (n_err == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("DONE: errors detected");
    $finish;
  end

endmodule
